// ----- sv/assert_macros.svh -----
// Concurrent assertion macros, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define HPSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a result field holds while its word waits to be taken.
`define HPSM_ASSERT_HOLD(name, sig, msg) \
  name: assert property (@(posedge clk) disable iff (rst) \
    (out_valid && !out_ready) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/hpsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hpsm_pkg;

  localparam int unsigned GAP_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SEC_W     = 23;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned ETA_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned FRAC_W    = 8;

  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned SEC_SHIFT = 38;
  localparam int unsigned PROD_W    = SEC_SHIFT + SEC_W;
  localparam int unsigned MULT_W    = GAP_W + SEC_W;

  localparam int unsigned DIVD_W    = MULT_W + FRAC_W;
  localparam int unsigned DIVS_W    = SEC_W;
  localparam int unsigned CNT_W     = 6;

  localparam logic [GAP_W-1:0]   GAP_RESET     = 16'd20;
  localparam logic [GAP_W-1:0]   STATION_RESET = 16'd200;
  localparam logic [SPEED_W-1:0] SPEED_MAX     = 24'd16776960;
  localparam logic [ETA_W-1:0]   ETA_MAX       = 32'hFFFF_FFFF;

  // Reciprocal of 1000 scaled by two to the 38th, rounded up.
  localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;

  localparam logic [CNT_W-1:0] SPEED_STEPS = CNT_W'(GAP_W + FRAC_W);
  localparam logic [CNT_W-1:0] ETA_STEPS   = CNT_W'(DIVD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP     = 1'b0,
    REG_STATION = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_WAIT_HIGH1 = 2'd0,
    PH_WAIT_LOW1  = 2'd1,
    PH_WAIT_HIGH2 = 2'd2,
    PH_WAIT_LOW2  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SPEED,
    ST_MULT,
    ST_ETA_GO,
    ST_ETA,
    ST_DONE
  } state_t;

  typedef enum logic {
    DIV_SPEED,
    DIV_ETA
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     eval;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_speed;
    logic     mult;
    logic     store_eta;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/hpsm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpsm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [hpsm_pkg::DIVD_W-1:0] dividend,
  input  wire logic [hpsm_pkg::DIVS_W-1:0] divisor,
  input  wire logic [hpsm_pkg::CNT_W-1:0]  steps,
  output logic                            done,
  output logic [hpsm_pkg::DIVD_W-1:0]     quotient
);
  import hpsm_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]   rem_sh;
  logic              take;
  logic [DIVS_W:0]   rem_sub;
  logic [DIVS_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quo[DIVD_W-1]};
    take     = rem_sh >= {1'b0, dsr};
    rem_sub  = rem_sh - {1'b0, dsr};
    rem_next = take ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= steps;
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], take};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- sv/hpsm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hpsm_pkg::status_t status,
  output hpsm_pkg::cmd_t         cmd
);
  import hpsm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.div_needed) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SPEED;
          state_next    = ST_SPEED;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SPEED: begin
        if (status.div_done) begin
          cmd.store_speed = 1'b1;
          state_next      = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_ETA_GO;
      end
      ST_ETA_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ETA;
        state_next    = ST_ETA;
      end
      ST_ETA: begin
        if (status.div_done) begin
          cmd.store_eta = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/hpsm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpsm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [hpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hpsm_pkg::GAP_W-1:0]     cfg_data,
  input  wire logic                          hall_level,
  input  wire logic [hpsm_pkg::TIME_W-1:0]    now_ms,
  input  wire hpsm_pkg::cmd_t                cmd,
  output hpsm_pkg::status_t                  status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               speed_valid,
  output logic [hpsm_pkg::SPEED_W-1:0]       speed_q8,
  output logic [hpsm_pkg::ETA_W-1:0]         eta_q8,
  output logic                               zero_interval
);
  import hpsm_pkg::*;

  logic [GAP_W-1:0]   gap_size_cm;
  logic [GAP_W-1:0]   station_distance_cm;
  logic               level;
  logic [PROD_W-1:0]  sec_prod;
  logic [SEC_W-1:0]   secs;
  phase_t             phase;
  logic [SEC_W-1:0]   start_second;
  logic [SEC_W-1:0]   diff;
  logic [SEC_W-1:0]   interval;
  logic               complete;
  logic               iv_zero;
  logic               gap_zero;
  logic [MULT_W-1:0]  eta_prod;
  logic               res_valid;
  logic [SPEED_W-1:0] res_speed;
  logic [ETA_W-1:0]   res_eta;
  logic               res_zero;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic [CNT_W-1:0]   div_steps;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_size_cm         <= GAP_RESET;
      station_distance_cm <= STATION_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAP:     gap_size_cm         <= cfg_data;
        REG_STATION: station_distance_cm <= cfg_data;
        default:     gap_size_cm         <= gap_size_cm;
      endcase
    end
  end

  // Whole seconds come from a reciprocal multiply, exact for any 32-bit time.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      level    <= hall_level;
      sec_prod <= PROD_W'(now_ms) * PROD_W'(SEC_RECIP);
    end
  end

  always_comb begin
    secs     = sec_prod[PROD_W-1:SEC_SHIFT];
    diff     = (secs >= start_second) ? (secs - start_second) : (start_second - secs);
    complete = (phase == PH_WAIT_LOW2) && !level;
    iv_zero  = (diff == '0);
    gap_zero = (gap_size_cm == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_HIGH1;
      start_second <= '0;
    end else if (cmd.eval) begin
      unique case (phase)
        PH_WAIT_HIGH1: if (level) phase <= PH_WAIT_LOW1;
        PH_WAIT_LOW1: begin
          if (!level) begin
            phase        <= PH_WAIT_HIGH2;
            start_second <= secs;
          end
        end
        PH_WAIT_HIGH2: if (level) phase <= PH_WAIT_LOW2;
        PH_WAIT_LOW2:  if (!level) phase <= PH_WAIT_HIGH1;
        default:       phase <= PH_WAIT_HIGH1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      interval  <= diff;
      res_valid <= complete;
      res_zero  <= complete && iv_zero;
      res_speed <= (complete && iv_zero) ? SPEED_MAX : '0;
      res_eta   <= (complete && !iv_zero && gap_zero) ? ETA_MAX : '0;
    end
    if (cmd.store_speed) begin
      res_speed <= div_q[SPEED_W-1:0];
    end
    if (cmd.mult) begin
      eta_prod <= MULT_W'(station_distance_cm) * MULT_W'(interval);
    end
    if (cmd.store_eta) begin
      res_eta <= (div_q[DIVD_W-1:ETA_W] != '0) ? ETA_MAX : div_q[ETA_W-1:0];
    end
  end

  always_comb begin
    if (cmd.div_sel == DIV_SPEED) begin
      div_dividend = {gap_size_cm, {(DIVD_W-GAP_W){1'b0}}};
      div_divisor  = diff;
      div_steps    = SPEED_STEPS;
    end else begin
      div_dividend = {eta_prod, {FRAC_W{1'b0}}};
      div_divisor  = DIVS_W'(gap_size_cm);
      div_steps    = ETA_STEPS;
    end
  end

  hpsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      speed_valid   <= res_valid;
      speed_q8      <= res_speed;
      eta_q8        <= res_eta;
      zero_interval <= res_zero;
    end
  end

  always_comb begin
    status.div_needed = complete && !iv_zero && !gap_zero;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ----- sv/hall_pulse_speed_meter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                Word
// in       in_valid / in_ready      hall_level, now_ms
// out      out_valid / out_ready    speed_valid, speed_q8, eta_q8, zero_interval
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A sample that completes no measurement skips the divider on its way to the next.
// A measurement with a nonzero interval and gap uses the one-bit-per-cycle shared divider:
// 24 steps for speed and 47 steps for the arrival estimate.
// Reset restores the register defaults and returns the tracker to waiting for a high sample.
// A result waits in the output register, so a stalled output holds off only the next result.

module hall_pulse_speed_meter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          hall_level,
  input  wire logic [hpsm_pkg::TIME_W-1:0]    now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               speed_valid,
  output logic [hpsm_pkg::SPEED_W-1:0]       speed_q8,
  output logic [hpsm_pkg::ETA_W-1:0]         eta_q8,
  output logic                               zero_interval,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hpsm_pkg::GAP_W-1:0]     cfg_data
);
  import hpsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hpsm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .hall_level    (hall_level),
    .now_ms        (now_ms),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .speed_valid   (speed_valid),
    .speed_q8      (speed_q8),
    .eta_q8        (eta_q8),
    .zero_interval (zero_interval)
  );

endmodule

`default_nettype wire

// ----- sv/hpsm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hpsm_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     speed_valid,
  input wire logic [hpsm_pkg::SPEED_W-1:0] speed_q8,
  input wire logic [hpsm_pkg::ETA_W-1:0]   eta_q8,
  input wire logic                     zero_interval
);
  import hpsm_pkg::*;

  `HPSM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "sample taken while busy")
  `HPSM_ASSERT(a_zero_interval_word, (out_valid && zero_interval) |-> (speed_valid && speed_q8 == SPEED_MAX && eta_q8 == '0), "zero interval word wrong")
  `HPSM_ASSERT(a_idle_word, (out_valid && !speed_valid) |-> (speed_q8 == '0 && eta_q8 == '0 && !zero_interval), "word without measurement not cleared")
  `HPSM_ASSERT_HOLD(a_hold_eta, eta_q8, "eta changed while stalled")

endmodule

bind hall_pulse_speed_meter_unit hpsm_checker u_hpsm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .speed_valid   (speed_valid),
  .speed_q8      (speed_q8),
  .eta_q8        (eta_q8),
  .zero_interval (zero_interval)
);

`default_nettype wire

// ----- bench/tb_hall_pulse_speed_meter_unit.sv -----
`timescale 1ns / 1ps

module tb_hall_pulse_speed_meter_unit;
  import hpsm_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] speed;
    logic [ETA_W-1:0]   eta;
    logic               zero;
  } speed_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 hall_level = 1'b0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 speed_valid;
  logic [SPEED_W-1:0]   speed_q8;
  logic [ETA_W-1:0]     eta_q8;
  logic                 zero_interval;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAP_W-1:0]     cfg_data = '0;

  phase_t               trk_phase = PH_WAIT_HIGH1;
  logic [SEC_W-1:0]     trk_start_sec = '0;
  logic [GAP_W-1:0]     gap_cm = GAP_RESET;
  logic [GAP_W-1:0]     station_cm = STATION_RESET;

  speed_report_t        pending_reports[$];
  speed_report_t        want_report;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  int  error_count = 0;
  int  samples_sent = 0;
  int  reports_checked = 0;
  int  measurements_seen = 0;
  int  zero_seen = 0;
  int  cfg_writes = 0;
  bit  in_held = 1'b0;

  hall_pulse_speed_meter_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .hall_level    (hall_level),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .speed_valid   (speed_valid),
    .speed_q8      (speed_q8),
    .eta_q8        (eta_q8),
    .zero_interval (zero_interval),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  function automatic speed_report_t predict_report(input logic lvl, input logic [TIME_W-1:0] ms);
    speed_report_t    r;
    logic [SEC_W-1:0] secs;
    logic [SEC_W-1:0] span;
    logic [63:0]      quot;
    r = '0;
    secs = SEC_W'(ms / 32'd1000);
    case (trk_phase)
      PH_WAIT_HIGH1: begin
        if (lvl) trk_phase = PH_WAIT_LOW1;
      end
      PH_WAIT_LOW1: begin
        if (!lvl) begin
          trk_phase = PH_WAIT_HIGH2;
          trk_start_sec = secs;
        end
      end
      PH_WAIT_HIGH2: begin
        if (lvl) trk_phase = PH_WAIT_LOW2;
      end
      PH_WAIT_LOW2: begin
        if (!lvl) begin
          trk_phase = PH_WAIT_HIGH1;
          r.done = 1'b1;
          span = (secs >= trk_start_sec) ? secs - trk_start_sec : trk_start_sec - secs;
          if (span == '0) begin
            r.zero = 1'b1;
            r.speed = SPEED_MAX;
          end else if (gap_cm == '0) begin
            r.eta = ETA_MAX;
          end else begin
            quot = (64'(gap_cm) << FRAC_W) / 64'(span);
            r.speed = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
            quot = ((64'(station_cm) * 64'(span)) << FRAC_W) / 64'(gap_cm);
            r.eta = (quot > 64'(ETA_MAX)) ? ETA_MAX : quot[ETA_W-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string label, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected word, expected none, actual %0d/%0d/%0d/%0d", $time,
                   speed_valid, speed_q8, eta_q8, zero_interval);
        end else begin
          want_report = pending_reports.pop_front();
          check_field("speed_valid", want_report.done, speed_valid);
          check_field("speed_q8", want_report.speed, speed_q8);
          check_field("eta_q8", want_report.eta, eta_q8);
          check_field("zero_interval", want_report.zero, zero_interval);
          reports_checked++;
          if (want_report.done) measurements_seen++;
          if (want_report.zero) zero_seen++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    @(negedge rst);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: no handshake for %0d cycles, %0d words outstanding", $time,
             idle_cycles, pending_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] ms);
    if ($urandom_range(99) < send_idle_pct) begin
      if (in_held) in_valid <= 1'b0;
      in_held = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    hall_level <= lvl;
    now_ms <= ms;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(predict_report(lvl, ms));
    samples_sent++;
  endtask

  task automatic wait_reports_drained();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_registers(input logic [GAP_W-1:0] gap, input logic [GAP_W-1:0] station);
    wait_reports_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_GAP;
    cfg_data <= gap;
    do @(posedge clk); while (!cfg_ready);
    gap_cm = gap;
    cfg_index <= REG_STATION;
    cfg_data <= station;
    do @(posedge clk); while (!cfg_ready);
    station_cm = station;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  task automatic send_measurement(input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                                  input bit noisy);
    send_sample(1'b1, $urandom());
    if (noisy && $urandom_range(3) == 0) send_sample(1'b1, $urandom());
    send_sample(1'b0, t0);
    if (noisy && $urandom_range(3) == 0) send_sample(1'b0, $urandom());
    send_sample(1'b1, $urandom());
    if (noisy && $urandom_range(3) == 0) send_sample(1'b1, $urandom());
    send_sample(1'b0, t1);
  endtask

  task automatic test_ignored_samples();
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd12345);
    send_sample(1'b0, 32'd0);
    send_sample(1'b0, 32'd2500);
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd9999);
    send_sample(1'b0, 32'd3000);
  endtask

  task automatic test_zero_interval();
    send_measurement(32'd7000, 32'd7999, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_registers(16'hFFFF, 16'd1);
    send_measurement(32'd1000, 32'd2999, 1'b0);
    write_registers(16'd1, 16'hFFFF);
    send_measurement(32'hFFFF_FFFF, 32'd0, 1'b0);
  endtask

  task automatic test_zero_gap();
    write_registers(16'd0, STATION_RESET);
    send_measurement(32'd0, 32'd5000, 1'b0);
  endtask

  task automatic test_random_traffic(input int count, input logic [GAP_W-1:0] gap,
                                     input logic [GAP_W-1:0] station);
    int                target;
    int                n;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    write_registers(gap, station);
    target = samples_sent + count;
    while (samples_sent < target) begin
      if ($urandom_range(99) < 80) begin
        t0 = $urandom();
        case ($urandom_range(4))
          0: t1 = t0 + $urandom_range(12000);
          1: t1 = t0 - $urandom_range(12000);
          2: t1 = t0 - (t0 % 1000) + $urandom_range(999);
          3: t1 = $urandom();
          default: begin
            t0 = 32'hFFFF_FFFF - $urandom_range(5000);
            t1 = $urandom_range(5000);
          end
        endcase
        send_measurement(t0, t1, 1'b1);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_sample(1'($urandom_range(1)), $urandom());
      end
    end
  endtask

  task automatic test_output_holdoff();
    int saved_send;
    int saved_recv;
    int k;
    saved_send = send_idle_pct;
    saved_recv = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 10; k++) begin
      send_measurement($urandom(), $urandom(), 1'b0);
    end
    wait_reports_drained();
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ignored_samples();
    test_zero_interval();
    test_register_extremes();
    test_zero_gap();

    test_random_traffic(250, 16'd1, 16'hFFFF);
    test_random_traffic(250, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    test_output_holdoff();

    send_idle_pct = 64;
    recv_idle_pct = 15;
    test_random_traffic(250, 16'hFFFF, 16'd1);
    test_random_traffic(250, GAP_RESET, STATION_RESET);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250, 16'hFFFF, 16'hFFFF);
    test_random_traffic(250, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));

    wait_reports_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d samples sent, %0d words checked, %0d measurements, %0d zero intervals.",
             samples_sent, reports_checked, measurements_seen, zero_seen);
    $display("Summary: %0d register writes over default, extreme and random settings; %0s",
             cfg_writes, "idling both ways, a long output hold-off and full-rate traffic.");
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
